[hw/rtl/triple_box_blur_argb_assert.svh]
// assertion macros used by the blur top level
// depends on aclk and aresetn being in scope where used
`ifndef TRIPLE_BOX_BLUR_ARGB_ASSERT_SVH
`define TRIPLE_BOX_BLUR_ARGB_ASSERT_SVH

// same-cycle implication
`define TBBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tbba_pkg.sv]
// shared constants and types for the three pass box blur
// no dependencies
`default_nettype none
package tbba_pkg;
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int PASSES      = 3;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = 12;
    localparam int PIX_W       = 32;
    localparam int CH_W        = 8;
    localparam int LANES       = 4;
    localparam int RAD_W       = 5;
    localparam int DIM_W       = 7;
    localparam int DIV_W       = RAD_W + 1;
    localparam int SUM_W       = 14;
    localparam int STEP_W      = 3;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef logic [SUM_W-1:0] chan_sum_t;
    typedef chan_sum_t [LANES-1:0] lane_sum_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

[hw/rtl/tbba_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module tbba_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/tbba_div.sv]
// four lane restoring divider, one quotient bit per cycle
// depends on tbba_pkg
`default_nettype none
module tbba_div
    import tbba_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire lane_sum_t        sums,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic [PIX_W-1:0]      quot
);
    logic              busy_reg;
    logic [STEP_W-1:0] bit_reg;
    lane_sum_t         rem_reg;
    logic [PIX_W-1:0]  quot_reg;
    logic [DIV_W-1:0]  div_reg;
    lane_sum_t         rem_next;
    logic [PIX_W-1:0]  quot_next;
    chan_sum_t         shifted;

    always_comb begin
        shifted   = chan_sum_t'({{(SUM_W-DIV_W){1'b0}}, div_reg} << bit_reg);
        rem_next  = rem_reg;
        quot_next = quot_reg;
        for (int l = 0; l < LANES; l++) begin
            if (rem_reg[l] >= shifted) begin
                rem_next[l] = rem_reg[l] - shifted;
                quot_next[l*CH_W + int'(bit_reg)] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                bit_reg  <= STEP_W'(CH_W - 1);
                rem_reg  <= sums;
                quot_reg <= '0;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quot_reg <= quot_next;
                bit_reg  <= bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quot = quot_reg;
endmodule
`default_nettype wire

[hw/rtl/triple_box_blur_argb.sv]
// top level of the three pass separable box blur with image and work rams
// depends on tbba_pkg, tbba_ram, tbba_div and triple_box_blur_argb_assert.svh
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_cmd, s_pixel_address, s_pixel_value
//  m_       out        m_valid/m_ready    m_done_kind, m_read_value
//  cfg      in         cfg_we             cfg_index, cfg_data
//
// pixel write: stored at the transfer; pixel read: via S_RDWAIT (ram latency)
// run: per tap a read state and an accumulate state, per output pixel a
//   divide (start, eight quotient bits, done), a write and the sliding states
//   S_SUB_RD, S_SUB, S_ADD_RD, S_ADD; serial, as each ram has one read port
// reset loads radius 1, width 64, height 64; ram contents are undefined
// s_ready is low while a command is in progress or the result slot is held
`default_nettype none
`include "triple_box_blur_argb_assert.svh"
module triple_box_blur_argb
    import tbba_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_cmd,
    input  wire logic [ADDR_W-1:0] s_pixel_address,
    input  wire logic [PIX_W-1:0]  s_pixel_value,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_done_kind,
    output logic [PIX_W-1:0]       m_read_value,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [DIM_W-1:0]  cfg_data
);
    localparam int POS_W  = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
    localparam int TAP_W  = POS_W + 2;
    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RDWAIT, S_INIT, S_INIT_ACC, S_DIV_GO, S_DIV, S_WRITE,
        S_SUB_RD, S_SUB, S_ADD_RD, S_ADD, S_FIN
    } state_t;

    typedef logic signed [TAP_W-1:0] tap_t;

    state_t            state_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic              dir_reg;          // 0 rows image to work, 1 columns back
    logic [PASS_W-1:0] pass_reg;
    logic [POS_W-1:0]  line_reg, pos_reg;
    tap_t              tap_reg;
    lane_sum_t         acc_reg;
    logic              m_valid_reg;
    logic [1:0]        m_kind_reg;
    logic [PIX_W-1:0]  m_value_reg;

    logic [DIM_W-1:0]  w_eff, h_eff, count, nlines;
    logic [POS_W-1:0]  last;
    tap_t              tap_sel;
    logic [POS_W-1:0]  tap_pos;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [PIX_W-1:0]  img_rdata, work_rdata, src_rdata;
    logic              in_xfer, out_xfer, img_we, work_we;
    logic [ADDR_W-1:0] img_waddr, img_raddr;
    logic [PIX_W-1:0]  img_wdata;
    div_ctl_t          div_ctl;
    logic [PIX_W-1:0]  mean;
    logic [DIV_W-1:0]  divisor;

    // clamp width and height to the supported range
    assign w_eff = (width_reg == '0) ? DIM_W'(1) :
                   (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? DIM_W'(1) :
                   (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
    assign count  = dir_reg ? h_eff : w_eff;
    assign nlines = dir_reg ? w_eff : h_eff;
    assign last   = POS_W'(count - 1'b1);
    assign divisor = {radius_reg, 1'b1};

    function automatic logic [POS_W-1:0] edge_clamp(tap_t v, logic [POS_W-1:0] lim);
        if (v < 0) begin
            return '0;
        end else if (v > $signed({2'b00, lim})) begin
            return lim;
        end
        return v[POS_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] line_addr(logic vert, logic [POS_W-1:0] ln,
                                                    logic [POS_W-1:0] idx,
                                                    logic [DIM_W-1:0] w);
        logic [2*DIM_W-1:0] prod;
        prod = vert ? (2*DIM_W)'(idx) * (2*DIM_W)'(w) : (2*DIM_W)'(ln) * (2*DIM_W)'(w);
        return ADDR_W'(prod + (2*DIM_W)'(vert ? ln : idx));
    endfunction

    // tap position for the read issued in this state
    always_comb begin
        unique case (state_reg)
            S_SUB_RD: tap_sel = $signed({2'b00, pos_reg}) - $signed({3'b000, radius_reg});
            S_ADD_RD: tap_sel = $signed({2'b00, pos_reg}) + $signed({3'b000, radius_reg})
                                + tap_t'(1);
            default:  tap_sel = tap_reg;
        endcase
    end

    assign tap_pos   = edge_clamp(tap_sel, last);
    assign rd_addr   = line_addr(dir_reg, line_reg, tap_pos, w_eff);
    assign wr_addr   = line_addr(dir_reg, line_reg, pos_reg, w_eff);
    assign src_rdata = dir_reg ? work_rdata : img_rdata;

    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid_reg && m_ready;

    // image ram serves pixel commands, row pass reads and column pass writes
    assign img_we    = (in_xfer && s_cmd == CMD_WRITE) || (state_reg == S_WRITE && dir_reg);
    assign img_waddr = (state_reg == S_IDLE) ? s_pixel_address : wr_addr;
    assign img_wdata = (state_reg == S_IDLE) ? s_pixel_value : mean;
    assign img_raddr = (state_reg == S_IDLE) ? s_pixel_address : rd_addr;
    assign work_we   = (state_reg == S_WRITE) && !dir_reg;

    tbba_ram #(.DEPTH(STORE_DEPTH), .WIDTH(PIX_W)) u_image_ram (
        .aclk  (aclk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    tbba_ram #(.DEPTH(STORE_DEPTH), .WIDTH(PIX_W)) u_work_ram (
        .aclk  (aclk),
        .we    (work_we),
        .waddr (wr_addr),
        .wdata (mean),
        .raddr (rd_addr),
        .rdata (work_rdata)
    );

    assign div_ctl.start = (state_reg == S_DIV_GO);

    tbba_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_ctl.start),
        .sums    (acc_reg),
        .divisor (divisor),
        .done    (div_ctl.done),
        .quot    (mean)
    );

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RAD_W'(1);
            width_reg  <= DIM_W'(64);
            height_reg <= DIM_W'(64);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_xfer) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        m_kind_reg <= s_cmd;
                        unique case (cmd_t'(s_cmd))
                            CMD_READ: state_reg <= S_RDWAIT;
                            CMD_RUN: begin
                                if (radius_reg == '0) begin
                                    state_reg <= S_FIN;
                                end else begin
                                    dir_reg   <= 1'b0;
                                    pass_reg  <= '0;
                                    line_reg  <= '0;
                                    pos_reg   <= '0;
                                    acc_reg   <= '0;
                                    tap_reg   <= -$signed({3'b000, radius_reg});
                                    state_reg <= S_INIT;
                                end
                            end
                            default: begin
                                m_value_reg <= '0;
                                m_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RDWAIT: begin
                    m_value_reg <= img_rdata;
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                S_INIT: state_reg <= S_INIT_ACC;
                S_INIT_ACC: begin
                    for (int l = 0; l < LANES; l++) begin
                        acc_reg[l] <= acc_reg[l] + SUM_W'(src_rdata[l*CH_W +: CH_W]);
                    end
                    if (tap_reg == $signed({3'b000, radius_reg})) begin
                        state_reg <= S_DIV_GO;
                    end else begin
                        tap_reg   <= tap_reg + tap_t'(1);
                        state_reg <= S_INIT;
                    end
                end
                S_DIV_GO: state_reg <= S_DIV;
                S_DIV: begin
                    if (div_ctl.done) begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (pos_reg != last) begin
                        state_reg <= S_SUB_RD;
                    end else begin
                        // line finished: next line, half pass, pass or finish
                        pos_reg <= '0;
                        acc_reg <= '0;
                        tap_reg <= -$signed({3'b000, radius_reg});
                        state_reg <= S_INIT;
                        if (line_reg != POS_W'(nlines - 1'b1)) begin
                            line_reg <= line_reg + 1'b1;
                        end else begin
                            line_reg <= '0;
                            dir_reg  <= ~dir_reg;
                            if (dir_reg) begin
                                if (pass_reg == PASS_W'(PASSES - 1)) begin
                                    state_reg <= S_FIN;
                                end else begin
                                    pass_reg <= pass_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                S_SUB_RD: state_reg <= S_SUB;
                S_SUB: begin
                    for (int l = 0; l < LANES; l++) begin
                        acc_reg[l] <= acc_reg[l] - SUM_W'(src_rdata[l*CH_W +: CH_W]);
                    end
                    state_reg <= S_ADD_RD;
                end
                S_ADD_RD: state_reg <= S_ADD;
                S_ADD: begin
                    for (int l = 0; l < LANES; l++) begin
                        acc_reg[l] <= acc_reg[l] + SUM_W'(src_rdata[l*CH_W +: CH_W]);
                    end
                    pos_reg   <= pos_reg + 1'b1;
                    state_reg <= S_DIV_GO;
                end
                S_FIN: begin
                    m_value_reg <= '0;
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_done_kind  = m_kind_reg;
    assign m_read_value = m_value_reg;

    `TBBA_ASSERT_NEXT(a_read_waits, in_xfer && s_cmd == CMD_READ, state_reg == S_RDWAIT, "read did not wait for ram")
    `TBBA_ASSERT_NOW(a_div_done_state, div_ctl.done, state_reg == S_DIV, "divider finished outside divide state")
    `TBBA_ASSERT_NOW(a_write_in_line, state_reg == S_WRITE, pos_reg <= last, "blur write beyond line end")
    `TBBA_ASSERT_NEXT(a_fin_result, state_reg == S_FIN, m_valid && m_done_kind == CMD_RUN, "run finished without result")
endmodule
`default_nettype wire

[sim/tb_triple_box_blur_argb.sv]
// self-checking testbench for the three pass box blur image store
// depends on tbba_pkg and the triple_box_blur_argb rtl
`timescale 1ns / 1ps

module tb_triple_box_blur_argb;
    import tbba_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;  // cycles with no command or result transfer
    localparam int ITEM_TARGET    = 650;
    localparam int QUIET_FROM     = 560;     // no idling after this many items
    localparam int HOLD_CYCLES    = 300;     // long receiver stall
    localparam int HOLD_AFTER     = 150;     // results seen before the long stall
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        cmd_t              kind;
        logic [PIX_W-1:0]  value;
    } blur_result_t;

    // predictor of the image store plus queue of pending results
    class blur_scoreboard;
        logic [PIX_W-1:0] image_mem[STORE_DEPTH];
        logic [PIX_W-1:0] work_mem[STORE_DEPTH];
        int               radius;
        int               width;
        int               height;
        blur_result_t     pending_q[$];
        int               errors;
        int               checked;

        function void reset_state();
            radius  = 1;
            width   = MAX_WIDTH;
            height  = MAX_HEIGHT;
            errors  = 0;
            checked = 0;
            pending_q.delete();
            for (int i = 0; i < STORE_DEPTH; i++) begin
                image_mem[i] = '0;
                work_mem[i]  = '0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [DIM_W-1:0] data);
            if (idx == CFG_RADIUS)
                radius = data[RAD_W-1:0];
            else if (idx == CFG_WIDTH)
                width = data;
            else if (idx == CFG_HEIGHT)
                height = data;
        endfunction

        // taps past either end take the edge pixel
        function int clamp_tap(int v, int last);
            if (v < 0) return 0;
            if (v > last) return last;
            return v;
        endfunction

        // one sliding window line, from image to work or work to image
        function void blur_line(bit from_work, int base, int step, int count, int r);
            int               acc[LANES];
            int               last;
            int               div;
            logic [PIX_W-1:0] src[MAX_WIDTH];
            logic [PIX_W-1:0] px;
            logic [PIX_W-1:0] mean;
            last = count - 1;
            div  = 2 * r + 1;
            for (int i = 0; i < count; i++)
                src[i] = from_work ? work_mem[base + i * step] : image_mem[base + i * step];
            for (int c = 0; c < LANES; c++) acc[c] = 0;
            for (int i = -r; i <= r; i++) begin
                px = src[clamp_tap(i, last)];
                for (int c = 0; c < LANES; c++) acc[c] += px[c*CH_W +: CH_W];
            end
            for (int i = 0; i <= last; i++) begin
                for (int c = 0; c < LANES; c++) mean[c*CH_W +: CH_W] = CH_W'(acc[c] / div);
                if (from_work) image_mem[base + i * step] = mean;
                else work_mem[base + i * step] = mean;
                px = src[clamp_tap(i - r, last)];
                for (int c = 0; c < LANES; c++) acc[c] -= px[c*CH_W +: CH_W];
                px = src[clamp_tap(i + r + 1, last)];
                for (int c = 0; c < LANES; c++) acc[c] += px[c*CH_W +: CH_W];
            end
        endfunction

        function void run_passes();
            int w;
            int h;
            w = (width < 1) ? 1 : (width > MAX_WIDTH ? MAX_WIDTH : width);
            h = (height < 1) ? 1 : (height > MAX_HEIGHT ? MAX_HEIGHT : height);
            if (radius == 0) return;
            for (int p = 0; p < PASSES; p++) begin
                for (int k = 0; k < h; k++) blur_line(1'b0, k * w, 1, w, radius);
                for (int k = 0; k < w; k++) blur_line(1'b1, k, w, h, radius);
            end
        endfunction

        function void note_input(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] val);
            blur_result_t res;
            res.kind  = cmd;
            res.value = '0;
            case (cmd)
                CMD_WRITE: image_mem[addr] = val;
                CMD_RUN:   run_passes();
                CMD_READ:  res.value = image_mem[addr];
                default: ;
            endcase
            pending_q.push_back(res);
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void check_result(logic [1:0] kind, logic [PIX_W-1:0] value);
            blur_result_t exp_res;
            checked++;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d value %h", kind, value));
                return;
            end
            exp_res = pending_q.pop_front();
            if (kind !== exp_res.kind)
                report_mismatch($sformatf("done_kind %0d, expected %0d", kind, exp_res.kind));
            if (value !== exp_res.value)
                report_mismatch($sformatf("read_value %h, expected %h", value, exp_res.value));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_cmd;
    logic [ADDR_W-1:0] s_pixel_address;
    logic [PIX_W-1:0]  s_pixel_value;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_done_kind;
    logic [PIX_W-1:0]  m_read_value;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [DIM_W-1:0]  cfg_data;

    blur_scoreboard    sb;
    bit                written[STORE_DEPTH];  // addresses that hold a defined pixel
    logic [ADDR_W-1:0] written_addrs[$];
    int                items_sent;
    bit                quiet;                 // no idling in the last part of the run
    int                idle_cycles;

    triple_box_blur_argb dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_pixel_address (s_pixel_address),
        .s_pixel_value   (s_pixel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_done_kind     (m_done_kind),
        .m_read_value    (m_read_value),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // one command transfer; payload holds until accepted
    task automatic send_cmd(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_pixel_address <= addr;
        s_pixel_value   <= val;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_input(cmd, addr, val);
        items_sent++;
        if (items_sent >= QUIET_FROM) quiet = 1'b1;
    endtask

    task automatic write_pixel(logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] val);
        send_cmd(CMD_WRITE, addr, val);
        if (!written[addr]) begin
            written[addr] = 1'b1;
            written_addrs.push_back(addr);
        end
    endtask

    // only reads of pixels that hold a defined value
    task automatic read_known_pixel();
        logic [ADDR_W-1:0] addr;
        addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        send_cmd(CMD_READ, addr, $urandom());
    endtask

    // every pixel the blur will tap must be defined first
    task automatic fill_region();
        int w;
        int h;
        w = (sb.width < 1) ? 1 : (sb.width > MAX_WIDTH ? MAX_WIDTH : sb.width);
        h = (sb.height < 1) ? 1 : (sb.height > MAX_HEIGHT ? MAX_HEIGHT : sb.height);
        for (int a = 0; a < w * h; a++)
            if (!written[a]) write_pixel(ADDR_W'(a), $urandom());
    endtask

    // wait until every result is back and the block has settled
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic set_geometry(logic [DIM_W-1:0] rad, logic [DIM_W-1:0] w,
                                logic [DIM_W-1:0] h);
        wait_drained();
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // result side: random bursts of back pressure plus one long stall
    initial begin
        bit held;
        int gap;
        held    = 1'b0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && sb.checked >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                gap = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result monitor
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_done_kind, m_read_value);
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results pending", sb.pending_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int ops;
        int pick;
        sb = new();
        sb.reset_state();
        items_sent      = 0;
        quiet           = 1'b0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_cmd           = CMD_WRITE;
        s_pixel_address = '0;
        s_pixel_value   = '0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_RADIUS;
        cfg_data        = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: field extremes and the unused command
        write_pixel(0, 32'h0000_0000);
        write_pixel(ADDR_W'(STORE_DEPTH - 1), 32'hFFFF_FFFF);
        write_pixel(12'hAAA, 32'hA5A5_5A5A);
        send_cmd(CMD_READ, ADDR_W'(STORE_DEPTH - 1), 32'h0);
        send_cmd(CMD_READ, 0, 32'hFFFF_FFFF);
        send_cmd(CMD_NOP, 12'hFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_READ, 12'hAAA, 32'h0);

        // zero radius leaves the image untouched
        set_geometry(0, 3, 2);
        fill_region();
        send_cmd(CMD_RUN, 0, 0);
        for (int a = 0; a < 6; a++) send_cmd(CMD_READ, ADDR_W'(a), 0);

        // widest radius, width above the maximum is clamped, single row
        set_geometry(31, 127, 1);
        fill_region();
        send_cmd(CMD_RUN, 12'h555, 32'h5555_5555);
        send_cmd(CMD_READ, 0, 0);
        send_cmd(CMD_READ, 63, 0);

        // zero width acts as one column, full height
        set_geometry(2, 0, 64);
        fill_region();
        send_cmd(CMD_RUN, 0, 0);
        send_cmd(CMD_READ, 0, 0);
        send_cmd(CMD_READ, 63, 0);
        send_cmd(CMD_READ, ADDR_W'(STORE_DEPTH - 1), 0);  // outside the blurred region

        // random phases with small images
        while (items_sent < ITEM_TARGET) begin
            set_geometry(DIM_W'($urandom_range(0, 31) >> $urandom_range(0, 3)),
                         DIM_W'($urandom_range(0, 9)), DIM_W'($urandom_range(0, 9)));
            fill_region();
            ops = $urandom_range(10, 30);
            for (int n = 0; n < ops; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 6)
                    write_pixel(ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), $urandom());
                else if (pick < 15)
                    read_known_pixel();
                else if (pick < 16)
                    send_cmd(CMD_NOP, ADDR_W'($urandom()), $urandom());
                else begin
                    fill_region();
                    send_cmd(CMD_RUN, ADDR_W'($urandom()), $urandom());
                end
            end
        end

        // final drain then settle
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
